@@ hw/rtl/salted_bloom_filter_macros.svh @@
// ----------------------------------------------------------------------------
// Salted Bloom filter assertion macros
// Shared assertion wrappers for the filter RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SALTED_BLOOM_FILTER_MACROS_SVH
`define SALTED_BLOOM_FILTER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, switched off while reset is held.
`define SBF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("salted_bloom_filter: assertion failed");
// Next-cycle implication, switched off while reset is held.
`define SBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("salted_bloom_filter: assertion failed");
`else
`define SBF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SBF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/sbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Salted Bloom filter package
// Field widths, command and register codes, remainder unit sizing and the
// salt table shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

    // Field widths of the word and the configuration registers.
    localparam int CMD_W   = 2;
    localparam int HASH_W  = 32;
    localparam int SLOT_W  = 10;
    localparam int DATA_W  = 32;
    localparam int TW_W    = 11;
    localparam int NS_W    = 7;
    localparam int BIT_W   = 5;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Register map, selected by address bit 2.
    localparam int         APB_ADDR_W      = 3;
    localparam logic       REG_TABLE_WORDS = 1'b0;
    localparam logic       REG_NUM_SALTS   = 1'b1;
    localparam logic [TW_W-1:0] TABLE_WORDS_RST = 11'd1024;
    localparam logic [NS_W-1:0] NUM_SALTS_RST   = 7'd4;

    // Remainder unit: a 27-bit word index dividend, padded to 28 bits and
    // consumed four bits per round.
    localparam int MOD_DVD_W  = HASH_W - BIT_W;
    localparam int MOD_DIGITS = 4;
    localparam int MOD_ROUNDS = (MOD_DVD_W + MOD_DIGITS - 1) / MOD_DIGITS;
    localparam int MOD_PAD_W  = MOD_ROUNDS * MOD_DIGITS;
    localparam int MOD_CNT_W  = $clog2(MOD_ROUNDS);

    // Salt table; the first entry is zero so probe zero uses the bare hash.
    localparam logic [NS_W-1:0] SALT_COUNT = 7'd65;
    localparam logic [HASH_W-1:0] SALT_ROM [0:64] = '{
        32'h00000000,
        32'h1953c322, 32'h588ccf17, 32'h64bf600c, 32'ha6be3f3d,
        32'h341a02ea, 32'h15b03217, 32'h3b062858, 32'h5956fd06,
        32'h18b5624f, 32'he3be0b46, 32'h20ffcd5c, 32'ha35dfd2b,
        32'h1fc4a9bf, 32'h57c45d5c, 32'ha8661c4a, 32'h4f1b74d2,
        32'h5a6dde13, 32'h3b18dac6, 32'h05a8afbf, 32'hbbda2fe2,
        32'ha2520d78, 32'he7934849, 32'hd541bc75, 32'h09a55b57,
        32'h9b345ae2, 32'hfc2d26af, 32'h38679cef, 32'h81bd1e0d,
        32'h654681ae, 32'h4b3d87ad, 32'hd5ff10fb, 32'h23b32f67,
        32'hafc7e366, 32'hdd955ead, 32'he7c34b1c, 32'hfeace0a6,
        32'heb16f09d, 32'h3c57a72d, 32'h2c8294c5, 32'hba92662a,
        32'hcd5b2d14, 32'h743936c8, 32'h2489beff, 32'hc6c56e00,
        32'h74a4f606, 32'hb244a94a, 32'h5edfc423, 32'hf1901934,
        32'h24af7691, 32'hf6c98b25, 32'hea25af46, 32'h76d5f2e6,
        32'h5e33cdf2, 32'h445eb357, 32'h88556bd2, 32'h70d1da7a,
        32'h54449368, 32'h381020bc, 32'h1c0520bf, 32'hf7e44942,
        32'ha27e2a58, 32'h66866fc5, 32'h12519ce7, 32'h437a8456
    };

endpackage

`default_nettype wire

@@ hw/rtl/salted_bloom_filter.sv @@
// ----------------------------------------------------------------------------
// Salted Bloom filter
// Each word carries a command and a 32-bit hash: insert sets one table bit per
// salted probe, query reports whether every probed bit is set, and read returns
// one table word. Exactly one result word follows every input word. The block
// takes one word at a time: an insert or query runs one probe per salt, and
// the probe count is num_salts, at most 65. Each probe is launched, passes
// through the remainder unit, which reduces the salted index by the table
// size four bits per clock, and then does a read-modify-write of the single
// table memory. After reset the table is swept to zero at one word per
// cycle, and no word is taken until the sweep ends; configuration writes are
// taken throughout. A finished result waits in the output register until it
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "salted_bloom_filter_macros.svh"

module salted_bloom_filter #(
    parameter int NUM_WORDS = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input channel.
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [sbf_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [sbf_pkg::HASH_W-1:0]         i_hash,
    input  wire logic [sbf_pkg::SLOT_W-1:0]         i_slot_index,
    // Result channel.
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_found,
    output logic      [sbf_pkg::DATA_W-1:0]         o_slot_data,
    output logic      [sbf_pkg::DATA_W-1:0]         o_words_included,
    output logic      [sbf_pkg::DATA_W-1:0]         o_collision_count,
    output logic                                    o_bad_index,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [sbf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [sbf_pkg::DATA_W-1:0]         pwdata,
    output logic      [sbf_pkg::DATA_W-1:0]         prdata,
    output logic                                    pready
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_START = 7'b0000100,
        S_MOD   = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [AW-1:0]                   r_clr_addr, n_clr_addr;
    logic [sbf_pkg::TW_W-1:0]        r_table_words;
    logic [sbf_pkg::NS_W-1:0]        r_num_salts;
    logic [sbf_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [sbf_pkg::HASH_W-1:0]      r_hash, n_hash;
    logic [sbf_pkg::TW_W-1:0]        r_words, n_words;
    logic [sbf_pkg::NS_W-1:0]        r_probes, n_probes;
    logic [sbf_pkg::NS_W-1:0]        r_probe, n_probe;
    logic [sbf_pkg::BIT_W-1:0]       r_bit, n_bit;
    logic [AW-1:0]                   r_word, n_word;
    logic                            r_any_new, n_any_new;
    logic                            r_all_set, n_all_set;
    logic                            r_bad, n_bad;
    logic [sbf_pkg::DATA_W-1:0]      r_data, n_data;
    logic [sbf_pkg::DATA_W-1:0]      r_incl, n_incl;
    logic [sbf_pkg::DATA_W-1:0]      r_coll, n_coll;
    logic                            r_out_valid, n_out_valid;
    logic                            r_found;
    logic [sbf_pkg::DATA_W-1:0]      r_slot_data;
    logic [sbf_pkg::DATA_W-1:0]      r_words_included;
    logic [sbf_pkg::DATA_W-1:0]      r_collision_count;
    logic                            r_bad_index;

    logic [sbf_pkg::TW_W-1:0]        w_eff_words;
    logic [sbf_pkg::NS_W-1:0]        w_eff_salts;
    logic [sbf_pkg::HASH_W-1:0]      w_probe_val;
    logic [sbf_pkg::DATA_W-1:0]      w_mask;
    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_load;
    logic                            w_found;
    logic                            w_cfg_we;
    logic                            w_mod_start;
    logic                            w_mod_done;
    logic [sbf_pkg::TW_W-1:0]        w_mod_rem;
    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [sbf_pkg::DATA_W-1:0]      w_wdata;
    logic                            w_re;
    logic [sbf_pkg::DATA_W-1:0]      w_rdata;

    // Configuration registers; zero words act as one, excess salts as 65.
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_words <= sbf_pkg::TABLE_WORDS_RST;
            r_num_salts   <= sbf_pkg::NUM_SALTS_RST;
        end else if (w_cfg_we) begin
            unique case (paddr[2])
                sbf_pkg::REG_TABLE_WORDS: begin
                    r_table_words <= pwdata[sbf_pkg::TW_W-1:0];
                end
                sbf_pkg::REG_NUM_SALTS: begin
                    r_num_salts <= pwdata[sbf_pkg::NS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sbf_pkg::REG_TABLE_WORDS: prdata = sbf_pkg::DATA_W'(r_table_words);
            sbf_pkg::REG_NUM_SALTS:   prdata = sbf_pkg::DATA_W'(r_num_salts);
            default:                  prdata = '0;
        endcase
    end

    // Effective table size and probe count.
    always_comb begin
        if (r_table_words == '0) begin
            w_eff_words = sbf_pkg::TW_W'(1);
        end else if (32'(r_table_words) > 32'(NUM_WORDS)) begin
            w_eff_words = sbf_pkg::TW_W'(NUM_WORDS);
        end else begin
            w_eff_words = r_table_words;
        end
        if (r_num_salts > sbf_pkg::SALT_COUNT) begin
            w_eff_salts = sbf_pkg::SALT_COUNT;
        end else begin
            w_eff_salts = r_num_salts;
        end
    end

    // Salted value of the current probe and the bit it selects in its word.
    assign w_probe_val = r_hash ^ sbf_pkg::SALT_ROM[r_probe];
    assign w_mask      = sbf_pkg::DATA_W'(1) << r_bit;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid & o_ready;
    assign w_out_free = !r_out_valid | i_ready;

    // Result flag for the finished word.
    always_comb begin
        case (r_cmd)
            sbf_pkg::CMD_INSERT: w_found = r_any_new;
            sbf_pkg::CMD_QUERY:  w_found = r_all_set;
            default:             w_found = 1'b0;
        endcase
    end

    // Sequencer: clearing sweep, probe launch, remainder wait, table
    // read-modify-write and result hand-over.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cmd       = r_cmd;
        n_hash      = r_hash;
        n_words     = r_words;
        n_probes    = r_probes;
        n_probe     = r_probe;
        n_bit       = r_bit;
        n_word      = r_word;
        n_any_new   = r_any_new;
        n_all_set   = r_all_set;
        n_bad       = r_bad;
        n_data      = r_data;
        n_incl      = r_incl;
        n_coll      = r_coll;
        w_load      = 1'b0;
        w_mod_start = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_word;
        w_wdata     = '0;
        w_re        = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                if (r_clr_addr == AW'(NUM_WORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd     = i_cmd;
                    n_hash    = i_hash;
                    n_words   = w_eff_words;
                    n_probes  = w_eff_salts;
                    n_probe   = '0;
                    n_any_new = 1'b0;
                    n_all_set = 1'b1;
                    n_bad     = 1'b0;
                    n_data    = '0;
                    case (i_cmd) inside
                        sbf_pkg::CMD_INSERT, sbf_pkg::CMD_QUERY: begin
                            n_state = (w_eff_salts == '0) ? S_DONE : S_START;
                        end
                        sbf_pkg::CMD_READ: begin
                            if ({1'b0, i_slot_index} < w_eff_words) begin
                                n_word  = AW'(i_slot_index);
                                n_state = S_READ;
                            end else begin
                                n_bad   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_START: begin
                w_mod_start = 1'b1;
                n_bit       = w_probe_val[sbf_pkg::BIT_W-1:0];
                n_state     = S_MOD;
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_word  = AW'(w_mod_rem);
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_re    = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cmd == sbf_pkg::CMD_READ) begin
                    n_data  = w_rdata;
                    n_state = S_DONE;
                end else begin
                    if ((w_rdata & w_mask) == '0) begin
                        n_all_set = 1'b0;
                        if (r_cmd == sbf_pkg::CMD_INSERT) begin
                            w_we      = 1'b1;
                            w_wdata   = w_rdata | w_mask;
                            n_any_new = 1'b1;
                        end
                    end
                    n_probe = r_probe + sbf_pkg::NS_W'(1);
                    n_state = (n_probe == r_probes) ? S_DONE : S_START;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == sbf_pkg::CMD_INSERT) begin
                        if (r_any_new) begin
                            n_incl = (r_incl == '1) ? r_incl : r_incl + 1'b1;
                        end else begin
                            n_coll = (r_coll == '1) ? r_coll : r_coll + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register holds a result until it is taken.
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_probe     <= '0;
            r_probes    <= '0;
            r_incl      <= '0;
            r_coll      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_probe     <= n_probe;
            r_probes    <= n_probes;
            r_incl      <= n_incl;
            r_coll      <= n_coll;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the word in progress.
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_hash    <= n_hash;
        r_words   <= n_words;
        r_bit     <= n_bit;
        r_word    <= n_word;
        r_any_new <= n_any_new;
        r_all_set <= n_all_set;
        r_bad     <= n_bad;
        r_data    <= n_data;
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_found           <= w_found;
            r_slot_data       <= r_data;
            r_words_included  <= n_incl;
            r_collision_count <= n_coll;
            r_bad_index       <= r_bad;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_found           = r_found;
    assign o_slot_data       = r_slot_data;
    assign o_words_included  = r_words_included;
    assign o_collision_count = r_collision_count;
    assign o_bad_index       = r_bad_index;

    // Shared remainder unit: word index of the salted probe mod table words.
    sbf_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_probe_val[sbf_pkg::HASH_W-1:sbf_pkg::BIT_W]),
        .i_divisor  (r_words),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    // Filter table.
    sbf_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_word),
        .o_rdata (w_rdata)
    );

    // The remainder is only reported while the sequencer waits for it.
    `SBF_ASSERT_IMPLIES(a_done_in_mod, i_clk, i_rst_n, w_mod_done, r_state == S_MOD)
    // Table reads and writes never share a cycle.
    `SBF_ASSERT_IMPLIES(a_no_rw_clash, i_clk, i_rst_n, w_we, !w_re)
    // Outside the clearing sweep only an insert writes the table.
    `SBF_ASSERT_IMPLIES(a_write_insert, i_clk, i_rst_n, w_we && (r_state != S_CLEAR), r_cmd == sbf_pkg::CMD_INSERT)
    // A probe is launched only while probes remain.
    `SBF_ASSERT_IMPLIES(a_probe_range, i_clk, i_rst_n, r_state == S_START, r_probe < r_probes)
    // Read data is consumed in the cycle after the read.
    `SBF_ASSERT_NEXT(a_read_check, i_clk, i_rst_n, r_state == S_READ, r_state == S_CHECK)

endmodule

`default_nettype wire

@@ hw/rtl/sbf_ram.sv @@
// ----------------------------------------------------------------------------
// Filter table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [sbf_pkg::DATA_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [sbf_pkg::DATA_W-1:0] o_rdata
);

    logic [sbf_pkg::DATA_W-1:0] r_mem [0:DEPTH-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with the data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sbf_mod_unit.sv @@
// ----------------------------------------------------------------------------
// Filter remainder unit
// Restoring remainder of a 27-bit word index by the table size in words,
// four dividend bits per clock, with a done pulse once the remainder is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_mod_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sbf_pkg::MOD_DVD_W-1:0] i_dividend,
    input  wire logic [sbf_pkg::TW_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic      [sbf_pkg::TW_W-1:0]      o_rem
);

    logic                              r_busy;
    logic [sbf_pkg::MOD_CNT_W-1:0]     r_cnt;
    logic [sbf_pkg::MOD_PAD_W-1:0]     r_dvd;
    logic [sbf_pkg::TW_W-1:0]          r_rem;
    logic [sbf_pkg::TW_W-1:0]          w_rem_step;
    logic [sbf_pkg::TW_W:0]            w_trial;

    // Four restoring steps per round; the divisor stays fixed while busy.
    // A partial remainder is always below the divisor, so a trial value is
    // below twice the divisor and one compare and subtract suffices.
    always_comb begin
        w_rem_step = r_rem;
        w_trial    = '0;
        for (int i = 0; i < sbf_pkg::MOD_DIGITS; i++) begin
            w_trial = {w_rem_step, r_dvd[sbf_pkg::MOD_PAD_W-1-i]};
            if (w_trial >= {1'b0, i_divisor}) begin
                w_rem_step = sbf_pkg::TW_W'(w_trial - {1'b0, i_divisor});
            end else begin
                w_rem_step = w_trial[sbf_pkg::TW_W-1:0];
            end
        end
    end

    // Round counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + sbf_pkg::MOD_CNT_W'(1);
                if (r_cnt == sbf_pkg::MOD_CNT_W'(sbf_pkg::MOD_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifter and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= sbf_pkg::MOD_PAD_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << sbf_pkg::MOD_DIGITS;
            r_rem <= w_rem_step;
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire
